@@ sv/fcg_pkg.sv @@
`timescale 1ns / 1ps
package fcg_pkg;

    localparam logic [31:0] MAT1     = 32'h8f70_11ee;
    localparam logic [31:0] MAT2     = 32'hfc78_ff1f;
    localparam logic [31:0] TMAT     = 32'h3793_fdff;
    localparam logic [31:0] MASK     = 32'h7fff_ffff;
    localparam logic [31:0] MIX_MULT = 32'd1812433253;

    localparam logic [31:0] CERT_W0 = 32'h0000_0054;
    localparam logic [31:0] CERT_W1 = 32'h0000_0049;
    localparam logic [31:0] CERT_W2 = 32'h0000_004e;
    localparam logic [31:0] CERT_W3 = 32'h0000_0059;

    localparam logic [2:0] MIX_FIRST = 3'd1;
    localparam logic [2:0] MIX_LAST  = 3'd7;
    localparam logic [2:0] PRE_FIRST = 3'd0;
    localparam logic [2:0] PRE_LAST  = 3'd7;

    localparam logic REQ_RESEED   = 1'b0;
    localparam logic REQ_GENERATE = 1'b1;

    localparam logic [7:0] REG_SOURCE_COUNT = 8'd0;
    localparam logic [7:0] REG_REPAIR_COUNT = 8'd1;

    typedef logic [3:0][31:0] words_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MIX,
        OP_CERT,
        OP_ADVANCE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [7:0] source_index;
        logic [7:0] repair_index;
        logic       last;
    } pos_t;

endpackage

@@ sv/fcg_state.sv @@
`timescale 1ns / 1ps
module fcg_state (
    input  logic          aclk,
    input  logic          aresetn,
    input  fcg_pkg::cmd_t cmd,
    input  logic [31:0]   seed,
    output logic [7:0]    coefficient
);
    import fcg_pkg::*;

    words_t      words_reg;
    words_t      words_next;
    words_t      adv;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] asel;
    logic [1:0]  rd_idx;
    logic [1:0]  wr_idx;
    logic [31:0] pmix;
    logic [31:0] mult;
    logic [31:0] t1;
    logic [31:0] t0;

    // one state update of the generator
    always_comb begin
        ax   = (words_reg[0] & MASK) ^ words_reg[1] ^ words_reg[2];
        ax   = ax ^ (ax << 1);
        ay   = words_reg[3] ^ (words_reg[3] >> 1) ^ ax;
        asel = {32{ay[0]}};
        adv[0] = words_reg[1];
        adv[1] = words_reg[2] ^ (asel & MAT1);
        adv[2] = ax ^ (ay << 10) ^ (asel & MAT2);
        adv[3] = ay;
    end

    // one initialization mixing step
    assign rd_idx = 2'(cmd.idx - 3'd1);
    assign wr_idx = cmd.idx[1:0];
    assign pmix   = words_reg[rd_idx] ^ (words_reg[rd_idx] >> 30);
    assign mult   = MIX_MULT * pmix;

    always_comb begin
        words_next = words_reg;
        case (cmd.op)
            OP_LOAD: begin
                words_next[0] = seed;
                words_next[1] = MAT1;
                words_next[2] = MAT2;
                words_next[3] = TMAT;
            end
            OP_MIX: begin
                words_next[wr_idx] = words_reg[wr_idx] ^ (32'(cmd.idx) + mult);
            end
            OP_CERT: begin
                if ((words_reg[0] & MASK) == 32'd0 && words_reg[1] == 32'd0 &&
                    words_reg[2] == 32'd0 && words_reg[3] == 32'd0) begin
                    words_next[0] = CERT_W0;
                    words_next[1] = CERT_W1;
                    words_next[2] = CERT_W2;
                    words_next[3] = CERT_W3;
                end
            end
            OP_ADVANCE: begin
                words_next = adv;
            end
            default: begin
                words_next = words_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg <= '0;
        end else begin
            words_reg <= words_next;
        end
    end

    // tempering of the current state
    assign t1 = words_reg[0] + (words_reg[2] >> 8);
    assign t0 = words_reg[3] ^ t1 ^ ({32{t1[0]}} & TMAT);
    assign coefficient = (t0[7:0] == 8'd0) ? 8'd1 : t0[7:0];

endmodule

@@ sv/fcg_position.sv @@
`timescale 1ns / 1ps
module fcg_position (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    input  logic          clear,
    input  logic          step,
    output fcg_pkg::pos_t pos
);
    import fcg_pkg::*;

    logic [7:0] source_count_reg;
    logic [7:0] repair_count_reg;
    logic [7:0] row_reg;
    logic [7:0] row_next;
    logic [7:0] col_reg;
    logic [7:0] col_next;
    logic [7:0] rows;
    logic [7:0] cols;
    logic       col_end;
    logic       row_end;

    assign rows    = (source_count_reg == 8'd0) ? 8'd1 : source_count_reg;
    assign cols    = (repair_count_reg == 8'd0) ? 8'd1 : repair_count_reg;
    assign col_end = col_reg >= (cols - 8'd1);
    assign row_end = row_reg >= (rows - 8'd1);

    assign pos.source_index = row_reg;
    assign pos.repair_index = col_reg;
    assign pos.last         = col_end && row_end;

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (clear) begin
            row_next = 8'd0;
            col_next = 8'd0;
        end else if (step) begin
            if (col_end) begin
                col_next = 8'd0;
                row_next = row_end ? 8'd0 : row_reg + 8'd1;
            end else begin
                col_next = col_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_count_reg <= 8'd1;
            repair_count_reg <= 8'd1;
            row_reg          <= 8'd0;
            col_reg          <= 8'd0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (cfg_we && cfg_index == REG_SOURCE_COUNT) begin
                source_count_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_REPAIR_COUNT) begin
                repair_count_reg <= cfg_data;
            end
        end
    end

endmodule

@@ sv/fec_coefficient_generator.sv @@
`timescale 1ns / 1ps
// Erasure-code coefficient generator on a TinyMT32 core (mat1 0x8f7011ee, mat2 0xfc78ff1f,
// tmat 0x3793fdff). A transaction with tuser 0 reseeds from tdata and clears the row and
// column positions; it yields no output and keeps the input busy through load, seven mixing
// steps, period certification and eight pre-loop updates, all run through the one shared
// state-update unit. A tuser 1 transaction runs an update and tempering and yields one
// coefficient with its row and column, tlast on the final one of the block; the result is
// registered, so the next request is taken while it waits. Registers: index 0 source_count,
// index 1 repair_count (0 acts as 1); the user writes them only while idle (not enforced).
module fec_coefficient_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // seed
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // coefficient, source_index, repair_index
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import fcg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_CERT,
        S_PRE,
        S_EMIT
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [23:0] m_tdata_reg;
    logic [23:0] m_tdata_next;
    logic        m_tlast_reg;
    logic        m_tlast_next;
    cmd_t        cmd;
    pos_t        pos;
    logic [7:0]  coefficient;
    logic        in_fire;
    logic        emit;
    logic        clear;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign clear     = in_fire && (s_tuser == REQ_RESEED);
    assign emit      = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    fcg_state u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .seed        (s_tdata),
        .coefficient (coefficient)
    );

    fcg_position u_position (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clear     (clear),
        .step      (emit),
        .pos       (pos)
    );

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd.op        = OP_NONE;
        cmd.idx       = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == REQ_RESEED) begin
                        cmd.op     = OP_LOAD;
                        step_next  = MIX_FIRST;
                        state_next = S_MIX;
                    end else begin
                        cmd.op     = OP_ADVANCE;
                        state_next = S_EMIT;
                    end
                end
            end
            S_MIX: begin
                cmd.op    = OP_MIX;
                step_next = step_reg + 3'd1;
                if (step_reg == MIX_LAST) begin
                    state_next = S_CERT;
                end
            end
            S_CERT: begin
                cmd.op     = OP_CERT;
                step_next  = PRE_FIRST;
                state_next = S_PRE;
            end
            S_PRE: begin
                cmd.op    = OP_ADVANCE;
                step_next = step_reg + 3'd1;
                if (step_reg == PRE_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                if (emit) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {pos.repair_index, pos.source_index, coefficient};
                    m_tlast_next  = pos.last;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
